### rtl/dual_fault_array_recorder_assert.svh
// ----------------------------------------------------------------------------
// dual fault array recorder assertion macros
// concurrent checks clocked on clock, held off during reset
// ----------------------------------------------------------------------------
`ifndef DUAL_FAULT_ARRAY_RECORDER_ASSERT_SVH
`define DUAL_FAULT_ARRAY_RECORDER_ASSERT_SVH

// condition holds at every edge
`define DFAR_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DFAR_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define DFAR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/dfar_pkg.sv
// ----------------------------------------------------------------------------
// dfar_pkg
// sizes, command codes and status codes of the dual fault array recorder
// ----------------------------------------------------------------------------
package dfar_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
   localparam int COUNT_W     = 5;
   localparam int RIDX_W      = 4;
   localparam int CMP_W       = (FILL_W > RIDX_W) ? FILL_W : RIDX_W;

   localparam int REQ_W  = 16;
   localparam int USER_W = 2;
   localparam int RSP_W  = 24;

   localparam logic [7:0] NO_FAULT = 8'h00;

   localparam logic [1:0] CMD_ADD     = 2'd0;
   localparam logic [1:0] CMD_CLR_CUR = 2'd1;
   localparam logic [1:0] CMD_CLR_REG = 2'd2;
   localparam logic [1:0] CMD_READ    = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef logic [FILL_W-1:0] fill_type;

   // low bits of a fill as seen on the count outputs
   function automatic logic [COUNT_W-1:0] to_count(input fill_type fill);
      return COUNT_W'(fill);
   endfunction

endpackage

### rtl/dual_fault_array_recorder.sv
// ----------------------------------------------------------------------------
// dual fault array recorder
// sequence: clear and add of code zero go straight to finish, read via read state,
//   other adds scan the current table, then, unless it is full, the registered one
// throughput: one item at a time; the scan compares one stored entry per cycle
//   through a single comparator shared by both tables, then appends the code
// reset: synchronous active-high, empties both tables and the result register
// ----------------------------------------------------------------------------
module dual_fault_array_recorder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // fault_code [7:0], read_index [11:8], read_registered [12], zero [15:13]
   input  logic [dfar_pkg::REQ_W-1:0]  req_tdata,
   // command [1:0]
   input  logic [dfar_pkg::USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // status [1:0], current_count [6:2], registered_count [11:7],
   // read_code [19:12], zero [23:20]
   output logic [dfar_pkg::RSP_W-1:0]  rsp_tdata
);
   import dfar_pkg::*;

   // sequencer states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_READ   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]         state_ff, state_in;

   // captured request fields
   logic [1:0]         cmd_ff;
   logic [7:0]         code_ff;
   logic [RIDX_W-1:0]  ridx_ff;

   // scan control: which table, which entry
   logic               tbl_sel_ff, tbl_sel_in;
   fill_type           scan_idx_ff, scan_idx_in;

   // fill counts of both tables
   fill_type           cur_fill_ff, cur_fill_in;
   fill_type           reg_fill_ff, reg_fill_in;

   // result being built
   logic [1:0]         status_ff, status_in;
   logic [7:0]         read_code_ff, read_code_in;

   // output register
   logic               rsp_valid_ff;
   logic [RSP_W-1:0]   rsp_data_ff;

   // table memories, read data registered
   logic [7:0]         cur_mem [TABLE_DEPTH];
   logic [7:0]         reg_mem [TABLE_DEPTH];
   logic [7:0]         cur_rd_ff, reg_rd_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               cur_we, reg_we;

   logic               req_accept;
   logic               rsp_free;
   logic               rsp_load;
   logic [7:0]         sel_data;
   fill_type           sel_fill;
   logic               scan_end;
   logic               hit;
   logic               read_hit;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // shared compare unit, works on whichever table the sequencer points at
   assign sel_data = tbl_sel_ff ? reg_rd_ff : cur_rd_ff;
   assign sel_fill = tbl_sel_ff ? reg_fill_ff : cur_fill_ff;
   assign scan_end = (scan_idx_ff >= sel_fill);
   assign hit      = (sel_data == code_ff);
   assign read_hit = (CMP_W'(ridx_ff) < CMP_W'(sel_fill));

   always_comb begin
      state_in     = state_ff;
      tbl_sel_in   = tbl_sel_ff;
      scan_idx_in  = scan_idx_ff;
      cur_fill_in  = cur_fill_ff;
      reg_fill_in  = reg_fill_ff;
      status_in    = status_ff;
      read_code_in = read_code_ff;
      cur_we       = 1'b0;
      reg_we       = 1'b0;
      rsp_load     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               status_in    = STATUS_OK;
               read_code_in = 8'h00;
               scan_idx_in  = '0;
               tbl_sel_in   = (req_tuser == CMD_READ) ? req_tdata[12] : 1'b0;
               unique case (req_tuser)
                  CMD_ADD: begin
                     state_in = (req_tdata[7:0] == NO_FAULT) ? S_FINISH : S_SCAN;
                  end
                  CMD_CLR_CUR: begin
                     cur_fill_in = '0;
                     state_in    = S_FINISH;
                  end
                  CMD_CLR_REG: begin
                     reg_fill_in = '0;
                     state_in    = S_FINISH;
                  end
                  default: begin
                     state_in = S_READ;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan_end) begin
               if (sel_fill >= FILL_W'(TABLE_DEPTH)) begin
                  // table full: stop here, registered side untouched if current full
                  status_in = STATUS_FULL;
                  state_in  = S_FINISH;
               end else begin
                  // code not present: append it
                  if (tbl_sel_ff) begin
                     reg_we      = 1'b1;
                     reg_fill_in = reg_fill_ff + FILL_W'(1);
                     state_in    = S_FINISH;
                  end else begin
                     cur_we      = 1'b1;
                     cur_fill_in = cur_fill_ff + FILL_W'(1);
                     tbl_sel_in  = 1'b1;
                     scan_idx_in = '0;
                  end
               end
            end else if (hit) begin
               // already recorded: move on to the registered table or finish
               if (tbl_sel_ff) begin
                  state_in = S_FINISH;
               end else begin
                  tbl_sel_in  = 1'b1;
                  scan_idx_in = '0;
               end
            end else begin
               scan_idx_in = scan_idx_ff + FILL_W'(1);
            end
         end
         S_READ: begin
            if (read_hit) begin
               read_code_in = sel_data;
            end else begin
               status_in = STATUS_RANGE;
            end
            state_in = S_FINISH;
         end
         default: begin
            // wait for room in the output register
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // read address: index of a read at idle, else next scan position so data lines up
   always_comb begin
      if (state_ff == S_IDLE && req_tuser == CMD_READ) begin
         rd_addr = IDX_W'(req_tdata[11:8]);
      end else begin
         rd_addr = scan_idx_in[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[cur_fill_ff[IDX_W-1:0]] <= code_ff;
      end
      cur_rd_ff <= cur_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reg_we) begin
         reg_mem[reg_fill_ff[IDX_W-1:0]] <= code_ff;
      end
      reg_rd_ff <= reg_mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_fill_ff  <= '0;
         reg_fill_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cur_fill_ff <= cur_fill_in;
         reg_fill_ff <= reg_fill_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff  <= req_tuser;
         code_ff <= req_tdata[7:0];
         ridx_ff <= req_tdata[11:8];
      end
      tbl_sel_ff   <= tbl_sel_in;
      scan_idx_ff  <= scan_idx_in;
      status_ff    <= status_in;
      read_code_ff <= read_code_in;
      if (rsp_load) begin
         rsp_data_ff <= {4'b0000, read_code_ff, to_count(reg_fill_ff),
                         to_count(cur_fill_ff), status_ff};
      end
   end

`include "dual_fault_array_recorder_assert.svh"

   `DFAR_ASSERT_ALWAYS(a_fill_bound, (cur_fill_ff <= FILL_W'(TABLE_DEPTH)) && (reg_fill_ff <= FILL_W'(TABLE_DEPTH)), "fill count beyond table depth")
   `DFAR_ASSERT_NEXT(a_busy_after_accept, req_accept, state_ff != S_IDLE, "sequencer idle right after a transfer in")
   `DFAR_ASSERT_IMPLY(a_full_only_on_add, (state_ff == S_FINISH) && (status_ff == STATUS_FULL), cmd_ff == CMD_ADD, "full status on a command other than add")

endmodule

### tb/dual_fault_array_recorder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual fault array recorder checker
// keeps its own copy of both fault tables, predicts the report of every
// accepted command and compares each returned report field by field
// ----------------------------------------------------------------------------
module dual_fault_array_recorder_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [dfar_pkg::REQ_W-1:0]  req_tdata,
   input  logic [dfar_pkg::USER_W-1:0] req_tuser,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [dfar_pkg::RSP_W-1:0]  rsp_tdata,
   output int                          fail_count,
   output int                          outstanding
);
   import dfar_pkg::*;

   localparam int CUR_TBL = 0;
   localparam int REG_TBL = 1;

   typedef struct packed {
      logic [1:0]         status;
      logic [COUNT_W-1:0] cur_count;
      logic [COUNT_W-1:0] reg_count;
      logic [7:0]         read_code;
   } fault_report_type;

   logic [7:0]       table_codes [2][TABLE_DEPTH];
   fill_type         table_fill  [2];
   fault_report_type awaited_reports [$];
   int               mismatches = 0;

   // empty one table
   function automatic void wipe_table(input int t);
      int i;
      for (i = 0; i < TABLE_DEPTH; i++) table_codes[t][i] = NO_FAULT;
      table_fill[t] = '0;
   endfunction

   // true if code is present or appended, false if absent from a full table
   function automatic bit record_code(input int t, input logic [7:0] code);
      int n;
      int i;
      n = int'(table_fill[t]);
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      for (i = 0; i < n; i++) begin
         if (table_codes[t][i] == code) return 1'b1;
      end
      if (n >= TABLE_DEPTH) return 1'b0;
      table_codes[t][n] = code;
      table_fill[t]     = fill_type'(n + 1);
      return 1'b1;
   endfunction

   function automatic fault_report_type apply_fault_command(input logic [1:0] cmd,
                                                            input logic [7:0] code,
                                                            input logic [3:0] idx,
                                                            input logic       sel);
      fault_report_type r;
      int               t;
      r        = '0;
      r.status = STATUS_OK;
      case (cmd)
         CMD_ADD: begin
            if (code != NO_FAULT) begin
               if (!record_code(CUR_TBL, code)) r.status = STATUS_FULL;
               else if (!record_code(REG_TBL, code)) r.status = STATUS_FULL;
            end
         end
         CMD_CLR_CUR: wipe_table(CUR_TBL);
         CMD_CLR_REG: wipe_table(REG_TBL);
         default: begin
            t = sel ? REG_TBL : CUR_TBL;
            if (idx < table_fill[t] && idx < TABLE_DEPTH) r.read_code = table_codes[t][idx];
            else r.status = STATUS_RANGE;
         end
      endcase
      r.cur_count = COUNT_W'(table_fill[CUR_TBL]);
      r.reg_count = COUNT_W'(table_fill[REG_TBL]);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      fault_report_type want;
      fault_report_type seen;
      if (reset) begin
         wipe_table(CUR_TBL);
         wipe_table(REG_TBL);
         awaited_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.status    = rsp_tdata[1:0];
            seen.cur_count = rsp_tdata[6:2];
            seen.reg_count = rsp_tdata[11:7];
            seen.read_code = rsp_tdata[19:12];
            if (awaited_reports.size() == 0) begin
               $error("report transfer with none outstanding: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = awaited_reports.pop_front();
               if (seen.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, seen.status);
                  mismatches++;
               end
               if (seen.cur_count !== want.cur_count) begin
                  $error("current_count: expected %0d, actual %0d",
                         want.cur_count, seen.cur_count);
                  mismatches++;
               end
               if (seen.reg_count !== want.reg_count) begin
                  $error("registered_count: expected %0d, actual %0d",
                         want.reg_count, seen.reg_count);
                  mismatches++;
               end
               if (seen.read_code !== want.read_code) begin
                  $error("read_code: expected %h, actual %h", want.read_code, seen.read_code);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_reports.push_back(apply_fault_command(req_tuser, req_tdata[7:0],
                                                          req_tdata[11:8], req_tdata[12]));
         end
      end
      fail_count  <= mismatches;
      outstanding <= awaited_reports.size();
   end

endmodule

### tb/tb_dual_fault_array_recorder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual fault array recorder testbench
// drives directed and random fault commands with random idle bursts on both
// channels; the checker beside the block predicts and compares every report
// ----------------------------------------------------------------------------
module tb_dual_fault_array_recorder;
   import dfar_pkg::*;

   localparam int  HALF_PERIOD  = 4;
   localparam int  RANDOM_ITEMS = 1875;
   // no idling on either side for the final stretch of commands
   localparam int  CALM_ITEMS   = 150;
   // longer than the worst add at depth 16, so this covers any late report
   localparam int  DRAIN_CYCLES = 40;
   // far above the slowest legal run
   localparam int  CYCLE_LIMIT  = 600000;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;
   logic [USER_W-1:0] req_tuser  = CMD_ADD;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b1;
   logic [RSP_W-1:0]  rsp_tdata;

   int fail_count;
   int outstanding;
   int cycle_count = 0;
   int stall_left  = 0;
   bit calm_tail   = 1'b0;

   always #(HALF_PERIOD) clock = ~clock;

   dual_fault_array_recorder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   dual_fault_array_recorder_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("dual_fault_array_recorder: mismatch");
         $finish;
      end
   end

   // report side back-pressure: random stall bursts, one update per edge
   always @(negedge clock) begin
      if (reset || calm_tail) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // one command transfer; entered and left at a falling edge, valid stays high
   // between back-to-back commands so it gets a single update per edge
   task automatic issue_command(input logic [1:0] cmd, input logic [7:0] code,
                                input logic [3:0] idx, input logic sel);
      int gap;
      if (!calm_tail && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      // fault_code [7:0], read_index [11:8], read_registered [12], zero [15:13]
      req_tdata  <= {3'b000, sel, idx, code};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // directed pass: extremes, every command and each corner of the tables
   task automatic directed_checks();
      int k;
      // add of the no-fault code changes nothing
      issue_command(CMD_ADD, NO_FAULT, 4'd0, 1'b0);
      // reads of empty tables are out of range
      issue_command(CMD_READ, 8'h00, 4'd0, 1'b0);
      issue_command(CMD_READ, 8'h00, 4'd15, 1'b1);
      // first code, then the same code again finds it present in both tables
      issue_command(CMD_ADD, 8'hFF, 4'd0, 1'b0);
      issue_command(CMD_ADD, 8'hFF, 4'd15, 1'b1);
      issue_command(CMD_READ, 8'h00, 4'd0, 1'b1);
      // fill both tables to the brim
      for (k = 1; k < TABLE_DEPTH; k++) issue_command(CMD_ADD, 8'(k), 4'(k), k[0]);
      // current table full: neither table takes the new code
      issue_command(CMD_ADD, 8'h80, 4'd0, 1'b0);
      // current cleared, registered still full: current keeps the code
      issue_command(CMD_CLR_CUR, 8'h00, 4'd0, 1'b0);
      issue_command(CMD_ADD, 8'h80, 4'd0, 1'b0);
      issue_command(CMD_READ, 8'h00, 4'd15, 1'b1);
      issue_command(CMD_READ, 8'h00, 4'd0, 1'b0);
      issue_command(CMD_CLR_REG, 8'hFF, 4'd15, 1'b1);
      issue_command(CMD_READ, 8'h00, 4'd0, 1'b1);
   endtask

   // random pass: mostly fill episodes drawn from a narrow code pool so that
   // repeats and full tables are common, with bursts of raw noise between them
   task automatic random_traffic(input int total);
      int         sent;
      int         len;
      int         span;
      int         pick;
      int         i;
      logic [7:0] base;
      sent = 0;
      while (sent < total) begin
         if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 6);
            for (i = 0; i < len && sent < total; i++) begin
               issue_command(2'($urandom), 8'($urandom), 4'($urandom), 1'($urandom));
               sent++;
               calm_tail = (sent >= total - CALM_ITEMS);
            end
         end else begin
            base = 8'($urandom);
            span = $urandom_range(4, 28);
            len  = $urandom_range(8, 48);
            // usually start the episode from one or both tables emptied
            pick = $urandom_range(0, 3);
            if (pick == 1 || pick == 3) begin
               issue_command(CMD_CLR_CUR, 8'($urandom), 4'($urandom), 1'($urandom));
               sent++;
            end
            if (pick == 2 || pick == 3) begin
               issue_command(CMD_CLR_REG, 8'($urandom), 4'($urandom), 1'($urandom));
               sent++;
            end
            for (i = 0; i < len && sent < total; i++) begin
               pick = $urandom_range(0, 31);
               if (pick < 19) begin
                  // pool codes may wrap through zero, which covers the no-fault add
                  issue_command(CMD_ADD, base + 8'($urandom_range(0, span - 1)),
                                4'($urandom), 1'($urandom));
               end else if (pick < 31) begin
                  issue_command(CMD_READ, 8'($urandom), 4'($urandom), 1'($urandom));
               end else begin
                  issue_command($urandom_range(0, 1) ? CMD_CLR_CUR : CMD_CLR_REG,
                                8'($urandom), 4'($urandom), 1'($urandom));
               end
               sent++;
               calm_tail = (sent >= total - CALM_ITEMS);
            end
         end
         calm_tail = (sent >= total - CALM_ITEMS);
      end
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      directed_checks();
      random_traffic(RANDOM_ITEMS);
      req_tvalid <= 1'b0;
      // wait for every report, then give a late extra report time to show up
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("dual_fault_array_recorder: match");
      end else begin
         $display("dual_fault_array_recorder: mismatch");
      end
      $finish;
   end

endmodule
